FILE: rtl/core/atrp_pkg.sv
// Package: widths, word types and the arctangent table for the tilt pipeline.
`default_nettype none
package atrp_pkg;
  localparam int SampleW   = 16;
  localparam int AngleW    = 16;
  localparam int CordicN   = 16;
  localparam int AccW      = 32;
  localparam int CordW     = 40;
  localparam int SumW      = 33;
  localparam int RootBits  = 32;
  localparam int ShW       = 5;
  localparam int RootW     = 32;

  typedef struct packed {
    logic signed [SampleW-1:0] accel_x;
    logic signed [SampleW-1:0] accel_y;
    logic signed [SampleW-1:0] accel_z;
  } in_word_t;

  typedef struct packed {
    logic signed [AngleW-1:0] roll_angle;
    logic signed [AngleW-1:0] pitch_angle;
    logic                     vector_invalid;
  } out_word_t;

  // Per-channel control carried along the pipe.
  typedef struct packed {
    logic num_neg;
    logic num_zero;
    logic den_zero;
    logic z_neg;
  } chan_flags_t;

  function automatic logic [AccW-1:0] atan_cd(input logic [4:0] i);
    logic [AccW-1:0] r;
    case (i)
      5'd0:  r = 32'd294912000;
      5'd1:  r = 32'd174096719;
      5'd2:  r = 32'd91987925;
      5'd3:  r = 32'd46694507;
      5'd4:  r = 32'd23437865;
      5'd5:  r = 32'd11730358;
      5'd6:  r = 32'd5866610;
      5'd7:  r = 32'd2933484;
      5'd8:  r = 32'd1466764;
      5'd9:  r = 32'd733385;
      5'd10: r = 32'd366693;
      5'd11: r = 32'd183346;
      5'd12: r = 32'd91673;
      5'd13: r = 32'd45837;
      5'd14: r = 32'd22918;
      5'd15: r = 32'd11459;
      5'd16: r = 32'd5730;
      5'd17: r = 32'd2865;
      5'd18: r = 32'd1432;
      5'd19: r = 32'd716;
      5'd20: r = 32'd358;
      5'd21: r = 32'd179;
      5'd22: r = 32'd90;
      5'd23: r = 32'd45;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/atrp_chan.sv
// One angle channel: square sum, normalize, square root, CORDIC, fold; fully pipelined.
`default_nettype none
module atrp_chan (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire logic signed [atrp_pkg::SampleW-1:0] num_i,
  input  wire logic signed [atrp_pkg::SampleW-1:0] a_i,
  input  wire logic signed [atrp_pkg::SampleW-1:0] b_i,
  output logic signed [atrp_pkg::AngleW-1:0]       angle_o
);
  import atrp_pkg::*;

  localparam int NumW  = SampleW + 1;
  // sum<<2s <= 2^62, root <= 2^31; run the root on 64-bit radicand
  localparam int RadW  = 64;
  localparam int NRoot = RootBits;
  localparam int NSt   = 2 + NRoot + CordicN + 1;

  // stage 0: magnitudes and squares
  logic [NumW-1:0]   nm_q;
  logic [SumW-1:0]   sum_q;
  chan_flags_t       f0_q;
  logic [NumW-1:0]   am, bm, nm;
  logic [2*NumW-1:0] am2, bm2;
  assign am = a_i[SampleW-1] ? NumW'(-$signed({a_i[SampleW-1], a_i})) : NumW'(a_i);
  assign bm = b_i[SampleW-1] ? NumW'(-$signed({b_i[SampleW-1], b_i})) : NumW'(b_i);
  assign nm = num_i[SampleW-1] ? NumW'(-$signed({num_i[SampleW-1], num_i})) : NumW'(num_i);
  assign am2 = am * am;
  assign bm2 = bm * bm;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nm_q  <= nm;
      sum_q <= SumW'(am2) + SumW'(bm2);
      f0_q  <= '{num_neg: num_i[SampleW-1], num_zero: (num_i == '0),
                 den_zero: 1'b0, z_neg: b_i[SampleW-1]};
    end
  end

  // stage 1: normalizing shift (leading-zero based), closed form of the model's search
  logic [ShW-1:0] s_d;
  always_comb begin
    logic [ShW:0] s1, s2;
    s1 = 6'd31;
    s2 = 6'd31;
    for (int k = 31; k >= 1; k--) begin
      if (64'(sum_q) > ((64'd1 << 62) >> (2 * k))) s1 = 6'(k - 1);
      if (64'(nm_q) > ((64'd1 << 31) >> k)) s2 = 6'(k - 1);
    end
    s_d = (s1 < s2) ? ShW'(s1) : ShW'(s2);
  end

  logic [RadW-1:0]  rad_q;
  logic [RootW-1:0] y0_q;
  chan_flags_t      f1_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q <= RadW'(sum_q) << (2 * s_d);
      y0_q  <= RootW'(64'(nm_q) << s_d);
      f1_q  <= '{num_neg: f0_q.num_neg, num_zero: f0_q.num_zero,
                 den_zero: (sum_q == '0), z_neg: f0_q.z_neg};
    end
  end

  // square root: one result bit per stage
  logic [RadW-1:0]  sr_rem_q [NRoot+1];
  logic [RootW-1:0] sr_res_q [NRoot+1];
  logic [RootW-1:0] sr_y_q   [NRoot+1];
  chan_flags_t      sr_f_q   [NRoot+1];
  always_comb begin
    sr_rem_q[0] = rad_q;
    sr_res_q[0] = '0;
    sr_y_q[0]   = y0_q;
    sr_f_q[0]   = f1_q;
  end
  for (genvar g = 0; g < NRoot; g++) begin : g_sqrt
    localparam int Sh = 2 * (NRoot - 1 - g);
    logic [RadW+1:0] trial;
    logic            take;
    assign trial = {2'b0, sr_rem_q[g]} -
                   ({RadW'(sr_res_q[g]), 2'b01} << Sh);
    assign take  = ~trial[RadW+1];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sr_rem_q[g+1] <= take ? trial[RadW-1:0] : sr_rem_q[g];
        sr_res_q[g+1] <= {sr_res_q[g][RootW-2:0], take};
        sr_y_q[g+1]   <= sr_y_q[g];
        sr_f_q[g+1]   <= sr_f_q[g];
      end
    end
  end

  // vectoring CORDIC, one iteration per stage
  logic signed [CordW-1:0] cx_q [CordicN+1];
  logic signed [CordW-1:0] cy_q [CordicN+1];
  logic signed [AccW:0]    ca_q [CordicN+1];
  chan_flags_t             cf_q [CordicN+1];
  always_comb begin
    cx_q[0] = CordW'(sr_res_q[NRoot]);
    cy_q[0] = CordW'(sr_y_q[NRoot]);
    ca_q[0] = '0;
    cf_q[0] = sr_f_q[NRoot];
  end
  for (genvar g = 0; g < CordicN; g++) begin : g_cordic
    logic signed [AccW:0] ang;
    assign ang = $signed({1'b0, atan_cd(5'(g))});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!cy_q[g][CordW-1]) begin
          cx_q[g+1] <= cx_q[g] + (cy_q[g] >>> g);
          cy_q[g+1] <= cy_q[g] - (cx_q[g] >>> g);
          ca_q[g+1] <= ca_q[g] + ang;
        end else begin
          cx_q[g+1] <= cx_q[g] - (cy_q[g] >>> g);
          cy_q[g+1] <= cy_q[g] + (cx_q[g] >>> g);
          ca_q[g+1] <= ca_q[g] - ang;
        end
        cf_q[g+1] <= cf_q[g];
      end
    end
  end

  // final: round, clamp, sign, fold
  logic signed [AngleW-1:0] ang_d;
  always_comb begin
    logic signed [AccW:0]     rr;
    logic signed [AngleW-1:0] t;
    chan_flags_t              f;
    f  = cf_q[CordicN];
    rr = (ca_q[CordicN] + (AccW+1)'(32768)) >>> 16;
    if (rr < 0) rr = '0;
    if (rr > 9000) rr = (AccW+1)'(9000);
    if (f.den_zero)      t = f.num_neg ? -16'sd9000 : 16'sd9000;
    else if (f.num_zero) t = '0;
    else                 t = f.num_neg ? -AngleW'(rr) : AngleW'(rr);
    if (f.z_neg) t = f.num_neg ? (-16'sd18000 - t) : (16'sd18000 - t);
    ang_d = t;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) angle_o <= ang_d;
  end

  logic unused_rst;
  assign unused_rst = rst_ni ^ (NSt == 0);
endmodule
`default_nettype wire

FILE: rtl/core/accel_tilt_roll_pitch.sv
// Throughput: one word per cycle unless the output stalls;
// a whole-pipe advance enable with a single output register.
// Depth is set by the 32 square-root stages and 16 CORDIC stages per angle.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none
module accel_tilt_roll_pitch (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire atrp_pkg::in_word_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output atrp_pkg::out_word_t       out_data_o
);
  import atrp_pkg::*;

  localparam int Lat = 2 + RootBits + CordicN + 1;

  logic en;
  logic [Lat-1:0] vld_q;
  logic [Lat-1:0] inv_q;
  logic signed [AngleW-1:0] roll, pitch;

  // advance when output slot is free or being taken, or the last stage holds no valid word
  assign en         = !out_valid_o || out_ready_i || !vld_q[Lat-1];
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) inv_q <= {inv_q[Lat-2:0], (in_data_i == '0)};
  end

  atrp_chan u_roll (
    .clk_i, .rst_ni, .en_i(en),
    .num_i(in_data_i.accel_y), .a_i(in_data_i.accel_x), .b_i(in_data_i.accel_z),
    .angle_o(roll)
  );
  atrp_chan u_pitch (
    .clk_i, .rst_ni, .en_i(en),
    .num_i(in_data_i.accel_x), .a_i(in_data_i.accel_y), .b_i(in_data_i.accel_z),
    .angle_o(pitch)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_ready_i || !out_valid_o) begin
      out_valid_o <= vld_q[Lat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if ((out_ready_i || !out_valid_o) && vld_q[Lat-1]) begin
      out_data_o.roll_angle     <= inv_q[Lat-1] ? '0 : roll;
      out_data_o.pitch_angle    <= inv_q[Lat-1] ? '0 : pitch;
      out_data_o.vector_invalid <= inv_q[Lat-1];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/atrp_checker.sv
// Port-level checker for the tilt pipeline, bound to the top level.
`default_nettype none
module atrp_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire atrp_pkg::out_word_t out_data_o
);
  import atrp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.vector_invalid |->
      out_data_o.roll_angle == '0 && out_data_o.pitch_angle == '0)
    else $error("invalid word with nonzero angle");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.roll_angle <= 18000 && out_data_o.roll_angle >= -18000 &&
      out_data_o.pitch_angle <= 18000 && out_data_o.pitch_angle >= -18000)
    else $error("angle out of range");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");
endmodule

bind accel_tilt_roll_pitch atrp_checker u_atrp_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);
`default_nettype wire
